// File: hdl/lfe_pkg.sv
// Shared types, constants and the B3/S23 cell rule for the Game of Life row stepper.
// Used by lfe_cell, lfe_rsp_queue and life_row_generation_step_top; depends on nothing.
`default_nettype none

package lfe_pkg;

   localparam int ROW_BITS    = 64;   // bits in one row field
   localparam int WIDTH_BITS  = 7;    // bits of the row width register
   localparam int QUEUE_DEPTH = 4;    // result queue entries
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd64;
   localparam logic [3:0]            BIRTH_COUNT   = 4'd3;
   localparam logic [3:0]            SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_cells;
      logic                last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] next_row;
      logic                is_last;
   } rsp_type;

   // Bits one column shows to its neighbors, already masked by the row width.
   typedef struct packed {
      logic above;
      logic pending;
      logic incoming;
   } nbr_type;

   // Next state of one cell from its own state and its eight neighbors.
   function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(nbrs[i]);
      end
      return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
   endfunction

endpackage

`default_nettype wire

// File: hdl/lfe_cell.sv
// One column of the row stepper: holds the column's bit of the row above and the pending row.
// Depends on lfe_pkg for the neighbor struct and the cell rule.
`default_nettype none

module lfe_cell (
   input  wire logic             clock,
   input  wire logic             col_en,
   input  wire logic             pend_valid,
   input  wire logic             load,
   input  wire logic             row_bit,
   input  wire lfe_pkg::nbr_type left_nbr,
   input  wire lfe_pkg::nbr_type right_nbr,
   output lfe_pkg::nbr_type      own_bits,
   output logic                  gen_next,
   output logic                  gen_last
);

   logic above_ff, above_in;
   logic pending_ff, pending_in;

   assign own_bits.above    = above_ff & col_en;
   assign own_bits.pending  = pending_ff & col_en;
   assign own_bits.incoming = row_bit & col_en;

   // Next state of the pending row, with the incoming row below it.
   assign gen_next = col_en & lfe_pkg::life_rule(own_bits.pending,
      {left_nbr.above, own_bits.above, right_nbr.above,
       left_nbr.pending, right_nbr.pending,
       left_nbr.incoming, own_bits.incoming, right_nbr.incoming});

   // Next state of the incoming row when it closes the grid: nothing below it.
   assign gen_last = col_en & lfe_pkg::life_rule(own_bits.incoming,
      {pend_valid & left_nbr.pending, pend_valid & own_bits.pending,
       pend_valid & right_nbr.pending,
       left_nbr.incoming, right_nbr.incoming, 3'b000});

   // The pending row moves up; with no pending row the row above is dead.
   assign above_in   = pend_valid & own_bits.pending;
   assign pending_in = own_bits.incoming;

   always_ff @(posedge clock) begin
      if (load) begin
         above_ff   <= above_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lfe_rsp_queue.sv
// Small result queue that takes up to two results per cycle and returns one per cycle while rsp_ready is high.
// Depends on lfe_pkg for the result struct and queue sizing.
`default_nettype none

module lfe_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_a,
   input  wire lfe_pkg::rsp_type data_a,
   input  wire logic             push_b,
   input  wire lfe_pkg::rsp_type data_b,
   output logic                  room_two,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lfe_pkg::rsp_type      rsp_payload
);

   lfe_pkg::rsp_type entry_ff [lfe_pkg::QUEUE_DEPTH];

   logic [lfe_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lfe_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lfe_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic [lfe_pkg::QPTR_BITS-1:0] wr_ptr_b;
   logic                          pop;

   assign pop         = rsp_valid & rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign room_two    = (count_ff <= lfe_pkg::QCNT_BITS'(lfe_pkg::QUEUE_DEPTH - 2));

   // The second result goes behind the first when both are pushed.
   assign wr_ptr_b  = push_a ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff + lfe_pkg::QPTR_BITS'(push_a) + lfe_pkg::QPTR_BITS'(push_b);
   assign rd_ptr_in = rd_ptr_ff + lfe_pkg::QPTR_BITS'(pop);
   assign count_in  = count_ff + lfe_pkg::QCNT_BITS'(push_a) + lfe_pkg::QCNT_BITS'(push_b)
                      - lfe_pkg::QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         entry_ff[wr_ptr_b] <= data_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/life_row_generation_step_top.sv
// Top level of the streaming Game of Life (B3/S23) row stepper.
// Depends on lfe_pkg, lfe_cell and lfe_rsp_queue.
//
// Usage:
//   The grid enters one row per transfer on the req_ channel (req_payload.row_cells,
//   bit j is column j, and req_payload.last_row on the final row). Each row after the
//   first releases the next generation of the row before it on the rsp_ channel. A row
//   marked last also releases its own next generation, flagged is_last, and the block
//   then starts afresh for the next grid. Cells outside the grid count as dead.
//   The csr_ channel writes row_width (columns in use); columns at or above it are dead
//   and read as zero. Write it only while no rows are in flight.
// Timing:
//   A result enters the result queue at the transfer of the row that releases it. Rows
//   are taken one per cycle while that queue has room for two results; a row that
//   releases two results offers both in turn. The rate is set by the four-entry
//   result queue and by the single result per cycle at rsp_.
// Reset and stalls:
//   Synchronous reset empties the queue, drops any pending row and sets row_width to 64;
//   req_ready and csr_ready stay low while reset is high. When the receiver stalls,
//   results wait in the queue and req_ready falls once fewer than two entries are free.
// The cell row is a chain of ROW_CELLS column cells, each exchanging its bits of the row
// above, the pending row and the incoming row with its neighbors every cycle.
`default_nettype none

module life_row_generation_step_top #(
   parameter int ROW_CELLS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lfe_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lfe_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lfe_pkg::WIDTH_BITS-1:0]      csr_data
);

   logic [lfe_pkg::WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           load;
   logic                           room_two;

   lfe_pkg::nbr_type           own_w [ROW_CELLS];
   logic [lfe_pkg::ROW_BITS-1:0] gen_next_w;
   logic [lfe_pkg::ROW_BITS-1:0] gen_last_w;

   lfe_pkg::rsp_type res_next;
   lfe_pkg::rsp_type res_last;
   lfe_pkg::rsp_type data_a;
   logic             push_a;
   logic             push_b;

   // The register port takes a write in every cycle outside reset.
   assign csr_ready    = ~reset;
   assign row_width_in = (csr_valid & csr_ready) ? csr_data : row_width_ff;

   // A row is taken only when both of its possible results fit in the queue.
   assign req_ready = room_two & ~reset;
   assign load      = req_valid & req_ready;

   // After a last row there is no pending row; otherwise the new row is now pending.
   assign pend_valid_in = load ? ~req_payload.last_row : pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= lfe_pkg::WIDTH_RESET;
         pend_valid_ff <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Chain of column cells; columns past ROW_CELLS are always dead.
   for (genvar j = 0; j < lfe_pkg::ROW_BITS; j++) begin : g_col
      if (j < ROW_CELLS) begin : g_cell
         lfe_pkg::nbr_type left_nbr;
         lfe_pkg::nbr_type right_nbr;
         logic             col_en;

         // Column j is in use when it lies below the configured width.
         assign col_en = (row_width_ff > lfe_pkg::WIDTH_BITS'(j));

         if (j == 0) begin : g_left_edge
            assign left_nbr = '0;
         end else begin : g_left
            assign left_nbr = own_w[j-1];
         end

         if (j == ROW_CELLS - 1) begin : g_right_edge
            assign right_nbr = '0;
         end else begin : g_right
            assign right_nbr = own_w[j+1];
         end

         lfe_cell u_cell (
            .clock      (clock),
            .col_en     (col_en),
            .pend_valid (pend_valid_ff),
            .load       (load),
            .row_bit    (req_payload.row_cells[j]),
            .left_nbr   (left_nbr),
            .right_nbr  (right_nbr),
            .own_bits   (own_w[j]),
            .gen_next   (gen_next_w[j]),
            .gen_last   (gen_last_w[j])
         );
      end else begin : g_dead
         assign gen_next_w[j] = 1'b0;
         assign gen_last_w[j] = 1'b0;
      end
   end

   assign res_next.next_row = gen_next_w;
   assign res_next.is_last  = 1'b0;
   assign res_last.next_row = gen_last_w;
   assign res_last.is_last  = 1'b1;

   // The pending row's result comes first; a last row adds its own result behind it.
   assign push_a = load & (pend_valid_ff | req_payload.last_row);
   assign push_b = load & pend_valid_ff & req_payload.last_row;
   assign data_a = pend_valid_ff ? res_next : res_last;

   lfe_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_a      (push_a),
      .data_a      (data_a),
      .push_b      (push_b),
      .data_b      (res_last),
      .room_two    (room_two),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: tb/sv/life_row_generation_step_top_test.sv
// Self-checking testbench for life_row_generation_step_top: streams Game of Life grids,
// predicts the next generation of every row and checks each result transfer against it.
// Depends on lfe_pkg and the life_row_generation_step_top RTL.

module life_row_generation_step_top_test;
   import lfe_pkg::*;

   // Keeps a private copy of the row stepper's state and the queue of rows it must return.
   class row_scoreboard;
      logic [WIDTH_BITS-1:0] row_width;
      logic [ROW_BITS-1:0]   above_row;
      logic [ROW_BITS-1:0]   pending_row;
      logic                  pending_valid;
      rsp_type               expected_rows[$];
      int                    errors;

      function new();
         row_width     = WIDTH_RESET;
         above_row     = '0;
         pending_row   = '0;
         pending_valid = 1'b0;
         errors        = 0;
      endfunction

      // Columns in use; widths above the row size saturate to the full row.
      function logic [ROW_BITS-1:0] live_mask();
         if (row_width >= ROW_BITS) begin
            return '1;
         end
         return ({{(ROW_BITS-1){1'b0}}, 1'b1} << row_width) - 1'b1;
      endfunction

      // B3/S23 over three rows; the rows are padded with one dead column on each side.
      function logic [ROW_BITS-1:0] next_generation(logic [ROW_BITS-1:0] up,
                                                    logic [ROW_BITS-1:0] mid,
                                                    logic [ROW_BITS-1:0] down,
                                                    logic [ROW_BITS-1:0] mask);
         logic [ROW_BITS+1:0] u, m, d;
         logic [ROW_BITS-1:0] res;
         int                  n;
         u   = {1'b0, up & mask, 1'b0};
         m   = {1'b0, mid & mask, 1'b0};
         d   = {1'b0, down & mask, 1'b0};
         res = '0;
         for (int j = 0; j < ROW_BITS; j++) begin
            n = int'(u[j]) + int'(u[j+1]) + int'(u[j+2]) + int'(m[j]) + int'(m[j+2])
              + int'(d[j]) + int'(d[j+1]) + int'(d[j+2]);
            res[j] = (n == BIRTH_COUNT) || (m[j+1] && (n == SURVIVE_COUNT));
         end
         return res & mask;
      endfunction

      function void take_row(req_type req);
         logic [ROW_BITS-1:0] mask;
         logic [ROW_BITS-1:0] row;
         rsp_type             r;
         mask = live_mask();
         row  = req.row_cells & mask;
         if (pending_valid) begin
            r.next_row = next_generation(above_row, pending_row, row, mask);
            r.is_last  = 1'b0;
            expected_rows.push_back(r);
            above_row = pending_row;
         end else begin
            above_row = '0;
         end
         pending_row   = row;
         pending_valid = 1'b1;
         if (req.last_row) begin
            r.next_row = next_generation(above_row, pending_row, '0, mask);
            r.is_last  = 1'b1;
            expected_rows.push_back(r);
            above_row     = '0;
            pending_row   = '0;
            pending_valid = 1'b0;
         end
      endfunction

      function void check_row(rsp_type got);
         rsp_type want;
         if (expected_rows.size() == 0) begin
            $display("%0t: result with none expected, got next_row %h is_last %b",
                     $time, got.next_row, got.is_last);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         if (got.next_row !== want.next_row) begin
            $display("%0t: next_row expected %h got %h", $time, want.next_row, got.next_row);
            errors++;
         end
         if (got.is_last !== want.is_last) begin
            $display("%0t: is_last expected %b got %b", $time, want.is_last, got.is_last);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_rows.size();
      endfunction
   endclass

   // Grids are sent in twelve phases of at least this many rows each, over 1450 in all.
   localparam int PHASES          = 12;
   localparam int ROWS_PER_PHASE  = 120;
   // Length of the long receiver hold-off that is meant to fill the result queue.
   localparam int HOLD_CYCLES     = 200;
   // Quiet cycles before a width write and at the very end. The block queues each result as
   // the row that releases it is taken, so no work is left in flight once all are returned.
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 20;
   // Cycles without any transfer before the run is declared hung. The worst legal quiet
   // stretch is the long hold-off plus a run of random receiver stalls.
   localparam int STALL_LIMIT     = 5000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WIDTH_BITS-1:0] csr_data;

   row_scoreboard sb;

   // Percent chances that the sender or the receiver sits out a cycle in the current phase.
   int send_idle   = 0;
   int recv_idle   = 0;
   // The main sequence bumps hold_asked; the receiver serves each request once.
   int hold_asked  = 0;
   int hold_served = 0;
   int stall_cycles = 0;

   life_row_generation_step_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // All transfers are observed here, at the rising edge, in one fixed order: the row
   // first, then the result, then the width write. Inputs only move at falling edges, so
   // nothing seen here depends on how the simulator orders events inside a time step.
   // The same process runs the watchdog on cycles that carry no transfer at all.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.take_row(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_row(rsp_payload);
         end
         if (csr_valid && csr_ready) begin
            sb.row_width = csr_data;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver side. Each falling edge it decides whether to take a result in the next
   // cycle. When a hold-off has been asked for, it keeps ready low for a long stretch,
   // counting the cycles itself, so the result queue fills and the block stops taking rows.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            rsp_ready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= recv_idle);
      end
   end

   // Random row content with a spread of densities, so that births, deaths and survivals
   // all occur often, and a share of rows that crowd the two outer columns on each side.
   function automatic logic [ROW_BITS-1:0] random_cells();
      logic [ROW_BITS-1:0] a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return a & b & c;
         3: return a & b;
         4: return a | b;
         5: return (a & b) | ({2'b11, {(ROW_BITS-4){1'b0}}, 2'b11} & c);
         default: return a;
      endcase
   endfunction

   // Offers one row and returns at the falling edge after its transfer, with valid still
   // high; the next call either keeps it high for the next row or lowers it for a gap.
   task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_payload.row_cells = cells;
      req_payload.last_row  = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops offering rows until every expected result has been returned.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Changes the row width; only called once the block has gone quiet after a full grid.
   task automatic write_width(input logic [WIDTH_BITS-1:0] width);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = width;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Whole grids of random height, each closed by a row marked last, so the block is back
   // at the start of a grid whenever a phase ends. Most grids are short; some are tall.
   // With pause set, the sender also waits for every result once, halfway through.
   task automatic send_grids(input int quota, input bit pause);
      int sent;
      int height;
      sent = 0;
      while (sent < quota) begin
         height = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
         for (int r = 0; r < height; r++) begin
            send_row(random_cells(), r == height - 1);
         end
         sent += height;
         if (pause && sent >= quota / 2) begin
            pause = 1'b0;
            drain();
         end
      end
   endtask

   // Hand-picked grids at the reset width of 64 columns.
   task automatic send_directed();
      // Single-row grids: both neighbor rows are dead.
      send_row('1, 1'b1);
      send_row('0, 1'b1);
      // Vertical blinker in column 1 turns horizontal.
      send_row(64'h2, 1'b0);
      send_row(64'h2, 1'b0);
      send_row(64'h2, 1'b1);
      // Blocks against both outer columns must stay put.
      send_row(64'hC000_0000_0000_0003, 1'b0);
      send_row(64'hC000_0000_0000_0003, 1'b0);
      send_row(64'h0, 1'b1);
      // A full grid: interior cells die of crowding, the corners survive.
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // Checkerboard rows.
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      // Glider near column 0.
      send_row(64'h2, 1'b0);
      send_row(64'h4, 1'b0);
      send_row(64'h7, 1'b0);
      send_row(64'h0, 1'b1);
   endtask

   // Width for each phase: the extremes of the 7-bit register, widths past the row size,
   // the narrowest rows and a few random widths. Phase 0 runs at the reset width.
   function automatic logic [WIDTH_BITS-1:0] phase_width(input int p);
      case (p)
         1: return 7'd1;
         2: return 7'd0;
         3: return 7'd127;
         4: return 7'd3;
         5: return 7'd65;
         6: return 7'd63;
         7: return 7'd2;
         8: return 7'd64;
         default: return WIDTH_BITS'($urandom_range(1, 64));
      endcase
   endfunction

   // Main sequence. Reset is held at the start, then the phases run in turn. The first
   // third has a lazy receiver, the second a lazy sender, the last has no idling. One phase
   // in each of the first and last thirds starts with a long receiver hold-off, and one in
   // each pauses the sender until all results are back.
   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p < 4) begin
            send_idle = 33;
            recv_idle = 87;
         end else if (p < 8) begin
            send_idle = 87;
            recv_idle = 33;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (p == 0) begin
            send_directed();
         end else begin
            write_width(phase_width(p));
         end
         if (p == 1 || p == 9) begin
            hold_asked++;
         end
         send_grids(ROWS_PER_PHASE, p == 2 || p == 10);
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/lfe_pkg.sv
hdl/lfe_cell.sv
hdl/lfe_rsp_queue.sv
hdl/life_row_generation_step_top.sv
tb/sv/life_row_generation_step_top_test.sv
